// ----- design/pva_pkg.sv -----
// pva_pkg: shared types and constants of the voice allocator
// used by pva_voice_store, pva_scan_unit and poly_voice_allocator_unit
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

	localparam int OP_W      = 2;
	localparam int KEY_W     = 7;
	localparam int VEL_W     = 7;
	localparam int IN_IDX_W  = 4;
	localparam int OUT_IDX_W = 4;
	localparam int MASK_W    = 16;

	localparam logic [OP_W-1:0] OP_NOTE_ON    = 2'd0;
	localparam logic [OP_W-1:0] OP_NOTE_OFF   = 2'd1;
	localparam logic [OP_W-1:0] OP_VOICE_IDLE = 2'd2;
	localparam logic [OP_W-1:0] OP_SILENCE    = 2'd3;

	// control of the voice store for one cycle
	typedef struct packed {
		logic rd_en;
		logic clr_all;
		logic clr_one;
		logic set_one;
		logic rank_we;
	} store_ctl_t;

	// control of the scan accumulators
	typedef struct packed {
		logic clear;
		logic acc_en;
	} scan_ctl_t;

endpackage

`default_nettype wire

// ----- design/pva_voice_store.sv -----
// pva_voice_store: per-voice busy flags, note memory and recency rank memory
// one registered read port walked by the sequencer; uses pva_pkg
`timescale 1ns / 1ps
`default_nettype none

module pva_voice_store #(
	parameter int POOL_SIZE = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire pva_pkg::store_ctl_t                  ctl,
	input  wire logic [$clog2(POOL_SIZE)-1:0]         rd_addr,
	input  wire logic [$clog2(POOL_SIZE)-1:0]         clr_idx,
	input  wire logic [$clog2(POOL_SIZE)-1:0]         set_idx,
	input  wire logic [pva_pkg::KEY_W-1:0]            note_wdata,
	input  wire logic [$clog2(POOL_SIZE)-1:0]         rank_waddr,
	input  wire logic [$clog2(POOL_SIZE+1)-1:0]       rank_wdata,
	output logic                                      rd_valid_s1,
	output logic [$clog2(POOL_SIZE)-1:0]              rd_idx_s1,
	output logic                                      busy_s1,
	output logic [pva_pkg::KEY_W-1:0]                 note_s1,
	output logic [$clog2(POOL_SIZE+1)-1:0]            rank_s1
);

	localparam int RW    = $clog2(POOL_SIZE+1);

	logic [POOL_SIZE-1:0]      busy_q;
	logic [POOL_SIZE-1:0]      rank_vld_q;
	logic [pva_pkg::KEY_W-1:0] note_mem [POOL_SIZE];
	logic [RW-1:0]             rank_mem [POOL_SIZE];
	logic [RW-1:0]             rank_raw_s1;
	logic                      rank_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			rank_vld_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= ctl.rd_en;
			if (ctl.clr_all) begin
				busy_q <= '0;
			end else if (ctl.clr_one) begin
				busy_q[clr_idx] <= 1'b0;
			end else if (ctl.set_one) begin
				busy_q[set_idx] <= 1'b1;
			end
			if (ctl.rank_we) begin
				rank_vld_q[rank_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.set_one) begin
			note_mem[set_idx] <= note_wdata;
		end
		if (ctl.rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		if (ctl.rd_en) begin
			rd_idx_s1   <= rd_addr;
			busy_s1     <= busy_q[rd_addr];
			note_s1     <= note_mem[rd_addr];
			rank_raw_s1 <= rank_mem[rd_addr];
			rank_vld_s1 <= rank_vld_q[rd_addr];
		end
	end

	// a rank never written reads as never assigned
	assign rank_s1 = rank_vld_s1 ? rank_raw_s1 : '0;

endmodule

`default_nettype wire

// ----- design/pva_scan_unit.sv -----
// pva_scan_unit: shared compare unit fed one voice per cycle
// finds the free or oldest voice, builds the release mask, computes rank updates; uses pva_pkg
`timescale 1ns / 1ps
`default_nettype none

module pva_scan_unit #(
	parameter int POOL_SIZE = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire pva_pkg::scan_ctl_t                   ctl,
	input  wire logic [$clog2(POOL_SIZE)-1:0]         idx_s1,
	input  wire logic                                 busy_s1,
	input  wire logic [pva_pkg::KEY_W-1:0]            note_s1,
	input  wire logic [$clog2(POOL_SIZE+1)-1:0]       rank_s1,
	input  wire logic [pva_pkg::KEY_W-1:0]            key,
	output logic [$clog2(POOL_SIZE)-1:0]              pick_idx,
	output logic                                      stolen,
	output logic [pva_pkg::MASK_W-1:0]                release_mask,
	output logic                                      upd_we,
	output logic [$clog2(POOL_SIZE+1)-1:0]            upd_rank
);

	localparam int IDX_W = $clog2(POOL_SIZE);
	localparam int RW    = $clog2(POOL_SIZE+1);
	localparam int MW    = (IDX_W > 5) ? IDX_W : 5;

	logic                       found_free_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic [RW-1:0]              free_rank_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [RW-1:0]              best_rank_q;
	logic [pva_pkg::MASK_W-1:0] mask_q;
	logic [pva_pkg::MASK_W-1:0] mask_hit;
	logic [RW-1:0]              old_rank;

	always_comb begin
		for (int b = 0; b < pva_pkg::MASK_W; b++) begin
			mask_hit[b] = busy_s1 && (note_s1 == key) && (MW'(idx_s1) == MW'(b));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_free_q <= 1'b0;
		end else if (ctl.clear) begin
			found_free_q <= 1'b0;
		end else if (ctl.acc_en && !busy_s1) begin
			found_free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			mask_q <= '0;
		end else if (ctl.acc_en) begin
			mask_q <= mask_q | mask_hit;
			if (!busy_s1 && !found_free_q) begin
				free_idx_q  <= idx_s1;
				free_rank_q <= rank_s1;
			end
			// first voice seeds the minimum, strict less keeps the lowest index on ties
			if (idx_s1 == '0 || rank_s1 < best_rank_q) begin
				best_idx_q  <= idx_s1;
				best_rank_q <= rank_s1;
			end
		end
	end

	assign pick_idx     = found_free_q ? free_idx_q : best_idx_q;
	assign old_rank     = found_free_q ? free_rank_q : best_rank_q;
	assign stolen       = !found_free_q;
	assign release_mask = mask_q;

	// picked voice becomes newest, newer ones move down by one
	always_comb begin
		upd_we   = 1'b0;
		upd_rank = rank_s1;
		if (idx_s1 == pick_idx) begin
			upd_we   = 1'b1;
			upd_rank = RW'(POOL_SIZE);
		end else if (rank_s1 != '0 && rank_s1 > old_rank) begin
			upd_we   = 1'b1;
			upd_rank = rank_s1 - RW'(1);
		end
	end

endmodule

`default_nettype wire

// ----- design/poly_voice_allocator_unit.sv -----
// poly_voice_allocator_unit: top level, command sequencer and result registers
// instantiates pva_voice_store and pva_scan_unit; uses pva_pkg
// note on scans the pool, then walks it again to update ranks; note off scans once; idle and silence act on accept
// the scan reads one voice a cycle through the store's single read port, twice for note on
// busy stays high for the whole scan; one result strobe per accepted command
// reset clears busy flags, recency ranks and the sequencer; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module poly_voice_allocator_unit #(
	parameter int POOL_SIZE = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [pva_pkg::OP_W-1:0]          op,
	input  wire logic [pva_pkg::KEY_W-1:0]         key,
	input  wire logic [pva_pkg::VEL_W-1:0]         velocity,
	input  wire logic [pva_pkg::IN_IDX_W-1:0]      idle_voice,
	output logic                                   busy,
	output logic                                   done,
	output logic                                   start_voice,
	output logic [pva_pkg::OUT_IDX_W-1:0]          voice_index,
	output logic                                   stolen,
	output logic [pva_pkg::KEY_W-1:0]              note_key,
	output logic [pva_pkg::VEL_W-1:0]              note_velocity,
	output logic [pva_pkg::MASK_W-1:0]             release_mask
);

	localparam int IDX_W = $clog2(POOL_SIZE);
	localparam int RW    = $clog2(POOL_SIZE+1);
	localparam int IW    = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_OFF_OUT,
		S_RANK,
		S_RDRAIN
	} state_t;

	state_t                     state_q;
	logic [IDX_W-1:0]           cnt_q;
	logic                       on_q;
	logic [pva_pkg::KEY_W-1:0]  key_q;
	logic [pva_pkg::VEL_W-1:0]  vel_q;

	logic                       accept;
	logic                       is_on;
	logic                       is_off;
	logic                       idle_ok;
	logic                       last_cnt;

	pva_pkg::store_ctl_t        st_ctl;
	pva_pkg::scan_ctl_t         sc_ctl;
	logic                       rd_valid_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic                       busy_s1;
	logic [pva_pkg::KEY_W-1:0]  note_s1;
	logic [RW-1:0]              rank_s1;
	logic [IDX_W-1:0]           pick_idx;
	logic                       scan_stolen;
	logic [pva_pkg::MASK_W-1:0] scan_mask;
	logic                       upd_we;
	logic [RW-1:0]              upd_rank;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign is_on    = (op == pva_pkg::OP_NOTE_ON) && (velocity != '0);
	assign is_off   = (op == pva_pkg::OP_NOTE_OFF) ||
	                  ((op == pva_pkg::OP_NOTE_ON) && (velocity == '0));
	assign idle_ok  = IW'(idle_voice) < IW'(POOL_SIZE);
	assign last_cnt = (cnt_q == IDX_W'(POOL_SIZE - 1));

	always_comb begin
		st_ctl.rd_en   = (state_q == S_SCAN) || (state_q == S_RANK);
		st_ctl.clr_all = accept && (op == pva_pkg::OP_SILENCE);
		st_ctl.clr_one = accept && (op == pva_pkg::OP_VOICE_IDLE) && idle_ok;
		st_ctl.set_one = (state_q == S_RDRAIN);
		st_ctl.rank_we = ((state_q == S_RANK) || (state_q == S_RDRAIN)) &&
		                 rd_valid_s1 && upd_we;
		sc_ctl.clear   = accept && (is_on || is_off);
		sc_ctl.acc_en  = ((state_q == S_SCAN) || (state_q == S_DRAIN)) && rd_valid_s1;
	end

	pva_voice_store #(
		.POOL_SIZE (POOL_SIZE)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (st_ctl),
		.rd_addr     (cnt_q),
		.clr_idx     (IDX_W'(idle_voice)),
		.set_idx     (pick_idx),
		.note_wdata  (key_q),
		.rank_waddr  (rd_idx_s1),
		.rank_wdata  (upd_rank),
		.rd_valid_s1 (rd_valid_s1),
		.rd_idx_s1   (rd_idx_s1),
		.busy_s1     (busy_s1),
		.note_s1     (note_s1),
		.rank_s1     (rank_s1)
	);

	pva_scan_unit #(
		.POOL_SIZE (POOL_SIZE)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (sc_ctl),
		.idx_s1       (rd_idx_s1),
		.busy_s1      (busy_s1),
		.note_s1      (note_s1),
		.rank_s1      (rank_s1),
		.key          (key_q),
		.pick_idx     (pick_idx),
		.stolen       (scan_stolen),
		.release_mask (scan_mask),
		.upd_we       (upd_we),
		.upd_rank     (upd_rank)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			on_q          <= 1'b0;
			key_q         <= '0;
			vel_q         <= '0;
			done          <= 1'b0;
			start_voice   <= 1'b0;
			voice_index   <= '0;
			stolen        <= 1'b0;
			note_key      <= '0;
			note_velocity <= '0;
			release_mask  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						on_q  <= is_on;
						key_q <= key;
						vel_q <= velocity;
						cnt_q <= '0;
						if (is_on || is_off) begin
							state_q <= S_SCAN;
						end else begin
							// idle and silence act at once and report all zero
							done          <= 1'b1;
							start_voice   <= 1'b0;
							voice_index   <= '0;
							stolen        <= 1'b0;
							note_key      <= '0;
							note_velocity <= '0;
							release_mask  <= '0;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (last_cnt) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					cnt_q   <= '0;
					state_q <= on_q ? S_RANK : S_OFF_OUT;
				end
				S_OFF_OUT: begin
					done          <= 1'b1;
					start_voice   <= 1'b0;
					voice_index   <= '0;
					stolen        <= 1'b0;
					note_key      <= '0;
					note_velocity <= '0;
					release_mask  <= scan_mask;
					state_q       <= S_IDLE;
				end
				S_RANK: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (last_cnt) begin
						state_q <= S_RDRAIN;
					end
				end
				S_RDRAIN: begin
					done          <= 1'b1;
					start_voice   <= 1'b1;
					voice_index   <= pva_pkg::OUT_IDX_W'(pick_idx);
					stolen        <= scan_stolen;
					note_key      <= key_q;
					note_velocity <= vel_q;
					release_mask  <= '0;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- dv/poly_voice_allocator_unit_tb.sv -----
// poly_voice_allocator_unit_tb: self-checking bench for the voice allocator
// drives note, idle and silence commands; checks each result against a voice pool model
// depends on pva_pkg and poly_voice_allocator_unit
`timescale 1ns / 1ps

module poly_voice_allocator_unit_tb;

	localparam int VOICES      = 16;
	localparam int RANK_W      = 5;
	localparam int RANDOM_CMDS = 400;
	localparam int SLOW_PCT    = 57;
	localparam int LIGHT_PCT   = 15;
	localparam int TAIL_CYCLES = 2*VOICES + 3 + 8;

	typedef struct {
		logic [pva_pkg::OP_W-1:0]     op;
		logic [pva_pkg::KEY_W-1:0]    key;
		logic [pva_pkg::VEL_W-1:0]    velocity;
		logic [pva_pkg::IN_IDX_W-1:0] idle_voice;
		int                           gap_pct;
		bit                           drain;
	} voice_cmd_t;

	typedef struct packed {
		logic                          start_voice;
		logic [pva_pkg::OUT_IDX_W-1:0] voice_index;
		logic                          stolen;
		logic [pva_pkg::KEY_W-1:0]     note_key;
		logic [pva_pkg::VEL_W-1:0]     note_velocity;
		logic [pva_pkg::MASK_W-1:0]    release_mask;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [pva_pkg::OP_W-1:0] op = pva_pkg::OP_SILENCE;
	logic [pva_pkg::KEY_W-1:0] key = '0;
	logic [pva_pkg::VEL_W-1:0] velocity = '0;
	logic [pva_pkg::IN_IDX_W-1:0] idle_voice = '0;
	logic busy;
	logic done;
	logic start_voice;
	logic [pva_pkg::OUT_IDX_W-1:0] voice_index;
	logic stolen;
	logic [pva_pkg::KEY_W-1:0] note_key;
	logic [pva_pkg::VEL_W-1:0] note_velocity;
	logic [pva_pkg::MASK_W-1:0] release_mask;

	voice_cmd_t    pending_cmds[$];
	alloc_result_t expected_results[$];
	int            mismatch_count = 0;

	// model of the voice pool
	logic                      voice_on[VOICES];
	logic [pva_pkg::KEY_W-1:0] voice_key[VOICES];
	logic [RANK_W-1:0]         voice_rank[VOICES];

	poly_voice_allocator_unit #(
		.POOL_SIZE(VOICES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.op(op),
		.key(key),
		.velocity(velocity),
		.idle_voice(idle_voice),
		.busy(busy),
		.done(done),
		.start_voice(start_voice),
		.voice_index(voice_index),
		.stolen(stolen),
		.note_key(note_key),
		.note_velocity(note_velocity),
		.release_mask(release_mask)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		for (int v = 0; v < VOICES; v++) begin
			voice_on[v] = 1'b0;
			voice_key[v] = '0;
			voice_rank[v] = '0;
		end
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
	endtask

	// advances the pool by one command and returns the result it should produce
	function automatic alloc_result_t allocate_voice(voice_cmd_t c);
		alloc_result_t r;
		logic [pva_pkg::OP_W-1:0] kind;
		int pick;
		logic [RANK_W-1:0] prev;
		r = '0;
		kind = c.op;
		if (kind == pva_pkg::OP_NOTE_ON && c.velocity == '0)
			kind = pva_pkg::OP_NOTE_OFF;
		case (kind)
		pva_pkg::OP_NOTE_ON: begin
			pick = -1;
			for (int v = 0; v < VOICES; v++)
				if (pick < 0 && !voice_on[v])
					pick = v;
			if (pick < 0) begin
				// pool full: steal the least recent, lowest index on ties
				pick = 0;
				for (int v = 1; v < VOICES; v++)
					if (voice_rank[v] < voice_rank[pick])
						pick = v;
				r.stolen = 1'b1;
			end
			voice_on[pick] = 1'b1;
			voice_key[pick] = c.key;
			prev = voice_rank[pick];
			for (int u = 0; u < VOICES; u++)
				if (u != pick && voice_rank[u] != '0 && voice_rank[u] > prev)
					voice_rank[u] = voice_rank[u] - 1'b1;
			voice_rank[pick] = RANK_W'(VOICES);
			r.start_voice = 1'b1;
			r.voice_index = pva_pkg::OUT_IDX_W'(pick);
			r.note_key = c.key;
			r.note_velocity = c.velocity;
		end
		pva_pkg::OP_NOTE_OFF: begin
			for (int v = 0; v < VOICES && v < pva_pkg::MASK_W; v++)
				if (voice_on[v] && voice_key[v] == c.key)
					r.release_mask[v] = 1'b1;
		end
		pva_pkg::OP_VOICE_IDLE: begin
			if (c.idle_voice < VOICES)
				voice_on[c.idle_voice] = 1'b0;
		end
		default: begin
			for (int v = 0; v < VOICES; v++)
				voice_on[v] = 1'b0;
		end
		endcase
		return r;
	endfunction

	// driver: presents the head command, predicts it on transfer
	always @(posedge clk) begin
		logic next_start;
		voice_cmd_t head;
		next_start = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(allocate_voice(pending_cmds[0]));
				void'(pending_cmds.pop_front());
			end
			if (start && busy) begin
				next_start = 1'b1;
			end else if (pending_cmds.size() > 0) begin
				head = pending_cmds[0];
				if (!(head.drain && expected_results.size() > 0) &&
						$urandom_range(0, 99) >= head.gap_pct) begin
					next_start = 1'b1;
					op <= head.op;
					key <= head.key;
					velocity <= head.velocity;
					idle_voice <= head.idle_voice;
				end
			end
		end
		start <= next_start;
	end

	// monitor: done marks one result, never held off
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(release_mask), '0);
			end else begin
				want = expected_results.pop_front();
				if (start_voice !== want.start_voice)
					report_mismatch("start_voice", 32'(start_voice), 32'(want.start_voice));
				if (voice_index !== want.voice_index)
					report_mismatch("voice_index", 32'(voice_index), 32'(want.voice_index));
				if (stolen !== want.stolen)
					report_mismatch("stolen", 32'(stolen), 32'(want.stolen));
				if (note_key !== want.note_key)
					report_mismatch("note_key", 32'(note_key), 32'(want.note_key));
				if (note_velocity !== want.note_velocity)
					report_mismatch("note_velocity", 32'(note_velocity),
						32'(want.note_velocity));
				if (release_mask !== want.release_mask)
					report_mismatch("release_mask", 32'(release_mask), 32'(want.release_mask));
			end
		end
	end

	task automatic add_cmd(input logic [pva_pkg::OP_W-1:0] c_op, input int c_key,
			input int c_vel, input int c_idle, input int gap_pct, input bit drain);
		voice_cmd_t c;
		c.op = c_op;
		c.key = pva_pkg::KEY_W'(c_key);
		c.velocity = pva_pkg::VEL_W'(c_vel);
		c.idle_voice = pva_pkg::IN_IDX_W'(c_idle);
		c.gap_pct = gap_pct;
		c.drain = drain;
		pending_cmds.push_back(c);
	endtask

	initial begin
		int key_pool[4];
		int pick;
		int gap_pct;
		int c_key;
		int c_vel;
		logic [pva_pkg::OP_W-1:0] c_op;

		// directed: field extremes, velocity zero, idle of an idle voice, silence, steal
		add_cmd(pva_pkg::OP_NOTE_ON, 127, 127, 15, 0, 0);
		add_cmd(pva_pkg::OP_NOTE_ON, 0, 1, 0, 0, 0);
		add_cmd(pva_pkg::OP_NOTE_ON, 127, 0, 0, 0, 0);
		add_cmd(pva_pkg::OP_NOTE_OFF, 0, 127, 15, 0, 0);
		add_cmd(pva_pkg::OP_NOTE_OFF, 5, 0, 0, 0, 0);
		add_cmd(pva_pkg::OP_VOICE_IDLE, 127, 127, 0, 0, 0);
		add_cmd(pva_pkg::OP_VOICE_IDLE, 0, 0, 0, 0, 0);
		add_cmd(pva_pkg::OP_VOICE_IDLE, 0, 0, 15, 0, 0);
		add_cmd(pva_pkg::OP_NOTE_ON, 33, 64, 0, 0, 0);
		add_cmd(pva_pkg::OP_SILENCE, 127, 127, 15, 0, 0);
		for (int i = 0; i < VOICES; i++)
			add_cmd(pva_pkg::OP_NOTE_ON, 60, $urandom_range(1, 127), 0, 0, 0);
		add_cmd(pva_pkg::OP_NOTE_OFF, 60, 0, 0, 0, 0);
		add_cmd(pva_pkg::OP_NOTE_ON, 99, 100, 0, 0, 0);

		foreach (key_pool[i])
			key_pool[i] = $urandom_range(0, 127);

		// random: note on is the most frequent op, to keep the pool full and force steals
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			case (i / 100)
			1: gap_pct = SLOW_PCT;
			2: gap_pct = LIGHT_PCT;
			default: gap_pct = 0;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 50)
				c_op = pva_pkg::OP_NOTE_ON;
			else if (pick < 75)
				c_op = pva_pkg::OP_NOTE_OFF;
			else if (pick < 96)
				c_op = pva_pkg::OP_VOICE_IDLE;
			else
				c_op = pva_pkg::OP_SILENCE;
			c_key = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 3)]
				: $urandom_range(0, 127);
			c_vel = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 127);
			add_cmd(c_op, c_key, c_vel, $urandom_range(0, 15), gap_pct, (i % 100) == 0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
design/pva_pkg.sv
design/pva_voice_store.sv
design/pva_scan_unit.sv
design/poly_voice_allocator_unit.sv
dv/poly_voice_allocator_unit_tb.sv
